// ===== hw/rtl/plist_pkg.sv =====
`timescale 1ns / 1ps
// Package for the positional list engine.
// Holds the command, status and sequencer state types and the result-load struct.
// Used by every module of the block; depends on nothing.
package plist_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LOC_W  = 16;
  localparam int unsigned POS_W  = 5;

  typedef enum logic [1:0] {
    FUNC_DISPLAY = 2'd0,
    FUNC_INSERT  = 2'd1,
    FUNC_DELETE  = 2'd2,
    FUNC_COUNT   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_STR_RD,
    ST_STR_OUT,
    ST_ONE
  } state_e;

  typedef struct packed {
    logic             load;
    logic             zero;
    logic [POS_W-1:0] pos;
    status_e          status;
    logic             last;
  } out_ctrl_t;

endpackage

// ===== hw/rtl/plist_mem.sv =====
`timescale 1ns / 1ps
// Element store of the positional list engine: one write port, one read port.
// The read data is registered and holds while no read is requested; needs plist_pkg.
module plist_mem import plist_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic signed [WORD_W-1:0] wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic signed [WORD_W-1:0] rdata_o
);

  logic signed [WORD_W-1:0] mem_q [DEPTH];
  logic signed [WORD_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/plist_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the positional list engine: decodes a command, moves elements
// through the store, then streams the list or gives one result. Needs plist_pkg.
module plist_ctrl import plist_pkg::*; #(
  parameter int unsigned LIST_CAPACITY = 16,
  parameter int unsigned IW            = 4,
  parameter int unsigned CW            = 5
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic signed [WORD_W-1:0] value_i,
  input  logic [LOC_W-1:0]         location_i,
  input  logic                     can_load_i,
  output out_ctrl_t                out_ctrl_o,
  output logic [CW-1:0]            cnt_o,
  output logic                     mem_we_o,
  output logic [IW-1:0]            mem_waddr_o,
  output logic signed [WORD_W-1:0] mem_wdata_o,
  output logic                     mem_re_o,
  output logic [IW-1:0]            mem_raddr_o,
  input  logic signed [WORD_W-1:0] mem_rdata_i
);

  state_e                   state_q, state_d;
  logic [IW-1:0]            ptr_q, ptr_d;
  logic [IW-1:0]            tgt_q, tgt_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic signed [WORD_W-1:0] val_q, val_d;
  status_e                  status_q, status_d;

  func_e         func;
  logic          list_full;
  logic          list_empty;
  logic          at_tgt;
  logic          at_end;
  logic [CW-1:0] ptr_inc;
  logic          str_last;
  logic [LOC_W-1:0] cnt_ext;
  logic          loc_low;

  assign func       = func_e'(func_i);
  assign list_full  = (cnt_q == CW'(LIST_CAPACITY));
  assign list_empty = (cnt_q == '0);
  assign at_tgt     = (ptr_q == tgt_q);
  assign at_end     = (ptr_q == IW'(cnt_q - CW'(1)));
  assign ptr_inc    = CW'(ptr_q) + CW'(1);
  assign str_last   = (ptr_inc == cnt_q);
  assign cnt_ext    = LOC_W'(cnt_q);
  assign loc_low    = (location_i <= LOC_W'(1));
  assign in_ready_o = (state_q == ST_IDLE);
  assign cnt_o      = cnt_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (func)
            FUNC_DISPLAY: state_d = list_empty ? ST_ONE : ST_STR_RD;
            FUNC_INSERT:  state_d = list_full ? ST_STR_RD : ST_INS_RD;
            FUNC_DELETE:  state_d = list_empty ? ST_ONE : ST_DEL_RD;
            default:      state_d = ST_ONE;
          endcase
        end
      end
      ST_INS_RD:  state_d = at_tgt ? ST_STR_RD : ST_INS_WR;
      ST_INS_WR:  state_d = ST_INS_RD;
      ST_DEL_RD: begin
        if (at_end) begin
          state_d = (cnt_q == CW'(1)) ? ST_ONE : ST_STR_RD;
        end else begin
          state_d = ST_DEL_WR;
        end
      end
      ST_DEL_WR:  state_d = ST_DEL_RD;
      ST_STR_RD:  state_d = ST_STR_OUT;
      ST_STR_OUT: state_d = (can_load_i && str_last) ? ST_IDLE : ST_STR_OUT;
      ST_ONE:     state_d = can_load_i ? ST_IDLE : ST_ONE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ptr_d       = ptr_q;
    tgt_d       = tgt_q;
    cnt_d       = cnt_q;
    val_d       = val_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = ptr_q;
    mem_wdata_o = mem_rdata_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;
    out_ctrl_o  = '{load: 1'b0, zero: 1'b0, pos: '0, status: status_q, last: 1'b0};
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          val_d    = value_i;
          ptr_d    = '0;
          status_d = STATUS_OK;
          case (func)
            FUNC_DISPLAY: status_d = list_empty ? STATUS_EMPTY : STATUS_OK;
            FUNC_INSERT: begin
              if (list_full) begin
                status_d = STATUS_FULL;
              end else begin
                ptr_d = IW'(cnt_q);
                if (loc_low) begin
                  tgt_d = '0;
                end else if (location_i > cnt_ext) begin
                  tgt_d = IW'(cnt_q);
                end else begin
                  tgt_d = IW'(location_i - LOC_W'(1));
                end
              end
            end
            FUNC_DELETE: begin
              if (list_empty) begin
                status_d = STATUS_EMPTY;
              end else begin
                if (loc_low) begin
                  ptr_d = '0;
                end else if (location_i >= cnt_ext) begin
                  ptr_d = IW'(cnt_q - CW'(1));
                end else begin
                  ptr_d = IW'(location_i - LOC_W'(1));
                end
              end
            end
            default: status_d = STATUS_OK;
          endcase
        end
      end
      ST_INS_RD: begin
        if (at_tgt) begin
          mem_we_o    = 1'b1;
          mem_wdata_o = val_q;
          cnt_d       = cnt_q + CW'(1);
          ptr_d       = '0;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q - IW'(1);
        end
      end
      ST_INS_WR: begin
        mem_we_o = 1'b1;
        ptr_d    = ptr_q - IW'(1);
      end
      ST_DEL_RD: begin
        if (at_end) begin
          cnt_d = cnt_q - CW'(1);
          ptr_d = '0;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = ptr_q + IW'(1);
        end
      end
      ST_DEL_WR: begin
        mem_we_o = 1'b1;
        ptr_d    = ptr_q + IW'(1);
      end
      ST_STR_RD: begin
        mem_re_o = 1'b1;
      end
      ST_STR_OUT: begin
        if (can_load_i) begin
          out_ctrl_o.load = 1'b1;
          out_ctrl_o.pos  = POS_W'(ptr_inc);
          out_ctrl_o.last = str_last;
          if (!str_last) begin
            ptr_d       = IW'(ptr_inc);
            mem_re_o    = 1'b1;
            mem_raddr_o = IW'(ptr_inc);
          end
        end
      end
      ST_ONE: begin
        out_ctrl_o.load = can_load_i;
        out_ctrl_o.zero = 1'b1;
        out_ctrl_o.last = 1'b1;
      end
      default: begin
        ptr_d = ptr_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      status_q <= STATUS_OK;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    tgt_q <= tgt_d;
    val_q <= val_d;
  end

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
`timescale 1ns / 1ps
// Top level of the positional list engine: sequencer, element store and result register.
// Needs plist_pkg, plist_ctrl and plist_mem.
//
// An ordered list of up to LIST_CAPACITY signed words with insert and delete by
// one-based position, display and count. The list lives in a single-port-write,
// registered-read store, and one sequencer walks it: an insert moves every
// element behind the insertion point up by one and a delete moves every element
// behind the removed one down by one, each move being a read followed by a write
// of the store. Insert, delete and display then stream a non-empty list front
// first, after a read setup state, one result per cycle while the output does
// not stall; a count or a command that finds or leaves the list empty gives one
// result. A new command is taken only once the previous one has handed its last
// result to the output register, at the earliest in the cycle after.
module positional_list_engine import plist_pkg::*; #(
  parameter int unsigned LIST_CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic signed [WORD_W-1:0] value_i,
  input  logic [LOC_W-1:0]         location_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [WORD_W-1:0] element_value_o,
  output logic [POS_W-1:0]         element_position_o,
  output logic [POS_W-1:0]         item_count_o,
  output logic [1:0]               status_o,
  output logic                     last_o
);

  localparam int unsigned IW = $clog2(LIST_CAPACITY);
  localparam int unsigned CW = $clog2(LIST_CAPACITY + 1);

  out_ctrl_t                out_ctrl;
  logic [CW-1:0]            cnt;
  logic                     can_load;
  logic                     mem_we;
  logic [IW-1:0]            mem_waddr;
  logic signed [WORD_W-1:0] mem_wdata;
  logic                     mem_re;
  logic [IW-1:0]            mem_raddr;
  logic signed [WORD_W-1:0] mem_rdata;

  logic                     out_valid_q;
  logic signed [WORD_W-1:0] value_q;
  logic [POS_W-1:0]         pos_q;
  logic [POS_W-1:0]         count_q;
  status_e                  status_q;
  logic                     last_q;

  assign can_load = !out_valid_q || out_ready_i;

  plist_ctrl #(
    .LIST_CAPACITY(LIST_CAPACITY),
    .IW           (IW),
    .CW           (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .value_i     (value_i),
    .location_i  (location_i),
    .can_load_i  (can_load),
    .out_ctrl_o  (out_ctrl),
    .cnt_o       (cnt),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  plist_mem #(
    .DEPTH(LIST_CAPACITY),
    .AW   (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ctrl.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ctrl.load) begin
      value_q  <= out_ctrl.zero ? '0 : mem_rdata;
      pos_q    <= out_ctrl.pos;
      count_q  <= POS_W'(cnt);
      status_q <= out_ctrl.status;
      last_q   <= out_ctrl.last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign element_value_o    = value_q;
  assign element_position_o = pos_q;
  assign item_count_o       = count_q;
  assign status_o           = status_q;
  assign last_o             = last_q;

endmodule

// ===== hw/rtl/plist_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the positional list engine, bound to the top level.
// Needs plist_pkg.
module plist_checker import plist_pkg::*; #(
  parameter int unsigned LIST_CAPACITY = 16
) (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [WORD_W-1:0] element_value_o,
  input logic [POS_W-1:0]         element_position_o,
  input logic [POS_W-1:0]         item_count_o,
  input logic [1:0]               status_o,
  input logic                     last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(element_value_o)
      && $stable(element_position_o) && $stable(last_o))
    else $error("Result changed while its transfer was stalled.");

  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("New command taken before the run finished.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Ready stayed high after a command transfer.");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_EMPTY) |->
      (item_count_o == '0) && (element_position_o == '0) && last_o)
    else $error("Empty-list result is malformed.");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_FULL) |-> (item_count_o == POS_W'(LIST_CAPACITY)))
    else $error("Refused insert reported a list that is not full.");

endmodule

bind positional_list_engine plist_checker #(.LIST_CAPACITY(LIST_CAPACITY)) u_plist_checker (.*);
